// ===== rtl/tas_pkg.sv =====
`default_nettype none

package tas_pkg;

    // Sample rate of the audio stream in Hz, and depth of the slew coefficient table.
    localparam int SAMPLE_RATE      = 48000;
    localparam int SLEW_TABLE_DEPTH = 256;

    // Only the first 256 entries can ever be addressed by an 8-bit slew code.
    localparam int ROM_N     = (SLEW_TABLE_DEPTH < 256) ? SLEW_TABLE_DEPTH : 256;
    localparam int ROM_IDX_W = $clog2(ROM_N);

    // Coefficients are Q16 and never exceed 1.0, so 17 bits hold them.
    localparam int COEF_W = 17;

    // Field widths.
    localparam int LEVEL_W = 16;
    localparam int CODE_W  = 8;
    localparam int CV_W    = 20;
    localparam int FRAC_W  = 16;
    localparam int SLEW_W  = CV_W + FRAC_W;

    // Saturation limits of the 20-bit signed range.
    localparam logic signed [CV_W-1:0] CV_MAX = {1'b0, {(CV_W-1){1'b1}}};
    localparam logic signed [CV_W-1:0] CV_MIN = {1'b1, {(CV_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic REG_TRIG_HIGH = 1'b0;
    localparam logic REG_TRIG_LOW  = 1'b1;

    // Threshold values after reset: 1 V and 0 V.
    localparam logic signed [LEVEL_W-1:0] TRIG_HIGH_RESET = 16'sd3277;
    localparam logic signed [LEVEL_W-1:0] TRIG_LOW_RESET  = 16'sd0;

    // Bit positions in the trigger state vector.
    localparam int TRIG_WRITE_GATE  = 0;
    localparam int TRIG_RESET_GATE  = 1;
    localparam int TRIG_WRITE_BTN   = 2;
    localparam int TRIG_RESET_BTN   = 3;

endpackage

`default_nettype wire

// ===== rtl/tas_coef_rom.sv =====
`default_nettype none

module tas_coef_rom (
    input  wire logic [tas_pkg::CODE_W-1:0] slew_code,
    output logic      [tas_pkg::COEF_W-1:0] coef
);

    logic [tas_pkg::COEF_W-1:0]    rom [tas_pkg::ROM_N];
    logic [tas_pkg::ROM_IDX_W-1:0] idx;

    // Each entry is 65536 * (1 - exp(-x)) with x = 255 / (rate * k * 10), from a
    // four-term series in Q40, all worked out at elaboration.
    for (genvar k = 0; k < tas_pkg::ROM_N; k++)
    begin : g_rom
        if (k == 0)
        begin : g_first
            assign rom[k] = tas_pkg::COEF_W'(65536);
        end
        else
        begin : g_entry
            localparam logic [127:0] D  = 128'(tas_pkg::SAMPLE_RATE) * 128'(k) * 128'd10;
            localparam logic [127:0] XR = (128'd255 << 40) / D;
            localparam logic [127:0] X  = (XR > 128'hFFFF_FFFF) ? 128'hFFFF_FFFF : XR;
            localparam logic [127:0] X2 = (X * X) >> 40;
            localparam logic [127:0] X3 = (X2 * X) >> 40;
            localparam logic [127:0] X4 = (X3 * X) >> 40;
            localparam logic [127:0] Y  = X - X2 / 2 + X3 / 6 - X4 / 24;
            localparam logic [127:0] C  = (Y + (128'd1 << 23)) >> 24;
            assign rom[k] = C[tas_pkg::COEF_W-1:0];
        end
    end

    // Codes beyond the table use its last entry.
    always_comb
    begin
        if ({1'b0, slew_code} > 9'(tas_pkg::ROM_N - 1))
            idx = tas_pkg::ROM_IDX_W'(tas_pkg::ROM_N - 1);
        else
            idx = slew_code[tas_pkg::ROM_IDX_W-1:0];
    end

    assign coef = rom[idx];

endmodule

`default_nettype wire

// ===== rtl/triggered_accumulator_slew_top.sv =====
`default_nettype none

// Triggered accumulator with slew limiter.
// Input channel (in_valid / in_ready) carries one audio sample per transfer:
// origin and delta voltages, a slew code, two gate levels and two button bits.
// Output channel (out_valid / out_ready) carries one result per sample: the
// slewed voltage and flags telling whether a write or reset trigger fired.
// A sample is held in an input register, processed combinationally (Schmitt
// triggers, accumulator, target, one-pole filter multiply) and written to the
// output register, which offers the result on out_valid.
// One sample per cycle is sustained while out_ready is high; the bound is the
// loop from the filter state through the coefficient multiply back into that state.
// When the receiver stalls, the finished result waits in the output register
// while one further sample waits in the input register; only then does
// in_ready drop.
// Reset clears the accumulator, the filter state and the trigger states,
// empties both registers and sets the thresholds to 1 V (high) and 0 V (low).
// Threshold writes on cfg_write take effect at once; the user must make them while idle (not enforced).

module triggered_accumulator_slew_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 cfg_write,
    input  wire logic                                 cfg_index,
    input  wire logic        [tas_pkg::LEVEL_W-1:0]   cfg_data,

    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [tas_pkg::LEVEL_W-1:0]   origin_level,
    input  wire logic signed [tas_pkg::LEVEL_W-1:0]   delta_level,
    input  wire logic        [tas_pkg::CODE_W-1:0]    slew_code,
    input  wire logic signed [tas_pkg::LEVEL_W-1:0]   write_gate,
    input  wire logic signed [tas_pkg::LEVEL_W-1:0]   reset_gate,
    input  wire logic                                 write_button,
    input  wire logic                                 reset_button,

    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed      [tas_pkg::CV_W-1:0]      cv_out,
    output logic                                      write_fired,
    output logic                                      reset_fired
);

    localparam int LW = tas_pkg::LEVEL_W;
    localparam int VW = tas_pkg::CV_W;
    localparam int SW = tas_pkg::SLEW_W;
    localparam int FW = tas_pkg::FRAC_W;
    localparam int PW = SW + 1 + tas_pkg::COEF_W + 1;

    // Configuration registers.
    logic signed [LW-1:0] trig_high_reg;
    logic signed [LW-1:0] trig_low_reg;

    // Input register.
    logic                 s1_valid_reg;
    logic signed [LW-1:0] origin_reg;
    logic signed [LW-1:0] delta_reg;
    logic [tas_pkg::CODE_W-1:0] code_reg;
    logic signed [LW-1:0] wgate_reg;
    logic signed [LW-1:0] rgate_reg;
    logic                 wbtn_reg;
    logic                 rbtn_reg;

    // Block state.
    logic signed [VW-1:0] acc_reg;
    logic signed [VW-1:0] acc_next;
    logic signed [SW-1:0] slew_reg;
    logic signed [SW-1:0] slew_next;
    logic [3:0]           trig_reg;
    logic [3:0]           trig_next;

    // Output register.
    logic                 out_valid_reg;
    logic signed [VW-1:0] cv_reg;
    logic signed [VW-1:0] cv_next;
    logic                 wfired_reg;
    logic                 rfired_reg;

    // Datapath.
    logic                 proc;
    logic                 wr_fire;
    logic                 rst_fire;
    logic signed [VW-1:0] acc_base;
    logic signed [VW:0]   acc_sum;
    logic signed [VW:0]   tgt_sum;
    logic signed [VW-1:0] target;
    logic signed [SW-1:0] target_q;
    logic signed [SW:0]   diff;
    logic [tas_pkg::COEF_W-1:0] coef;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] step;
    logic signed [SW:0]   slew_rnd;
    logic signed [SW-FW:0] cv_wide;

    // Handshake: the input register moves on whenever the output register is free.
    assign proc      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign cv_out    = cv_reg;
    assign write_fired = wfired_reg;
    assign reset_fired = rfired_reg;

    tas_coef_rom u_rom (
        .slew_code (code_reg),
        .coef      (coef)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_high_reg <= tas_pkg::TRIG_HIGH_RESET;
            trig_low_reg  <= tas_pkg::TRIG_LOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tas_pkg::REG_TRIG_HIGH: trig_high_reg <= cfg_data;
                tas_pkg::REG_TRIG_LOW:  trig_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Schmitt triggers on the gates and edge detectors on the buttons.
    always_comb
    begin
        trig_next = trig_reg;
        wr_fire   = 1'b0;
        rst_fire  = 1'b0;

        if (trig_reg[tas_pkg::TRIG_RESET_GATE])
        begin
            if (rgate_reg <= trig_low_reg)
                trig_next[tas_pkg::TRIG_RESET_GATE] = 1'b0;
        end
        else if (rgate_reg >= trig_high_reg)
        begin
            trig_next[tas_pkg::TRIG_RESET_GATE] = 1'b1;
            rst_fire = 1'b1;
        end

        if (trig_reg[tas_pkg::TRIG_WRITE_GATE])
        begin
            if (wgate_reg <= trig_low_reg)
                trig_next[tas_pkg::TRIG_WRITE_GATE] = 1'b0;
        end
        else if (wgate_reg >= trig_high_reg)
        begin
            trig_next[tas_pkg::TRIG_WRITE_GATE] = 1'b1;
            wr_fire = 1'b1;
        end

        trig_next[tas_pkg::TRIG_RESET_BTN] = rbtn_reg;
        trig_next[tas_pkg::TRIG_WRITE_BTN] = wbtn_reg;
        if (rbtn_reg && !trig_reg[tas_pkg::TRIG_RESET_BTN])
            rst_fire = 1'b1;
        if (wbtn_reg && !trig_reg[tas_pkg::TRIG_WRITE_BTN])
            wr_fire = 1'b1;
    end

    // Accumulator: clear on reset trigger, then add the delta on write trigger.
    always_comb
    begin
        acc_base = rst_fire ? '0 : acc_reg;
        acc_sum  = (VW + 1)'(acc_base) + (VW + 1)'(delta_reg);
        if (!wr_fire)
            acc_next = acc_base;
        else if (acc_sum > (VW + 1)'(tas_pkg::CV_MAX))
            acc_next = tas_pkg::CV_MAX;
        else if (acc_sum < (VW + 1)'(tas_pkg::CV_MIN))
            acc_next = tas_pkg::CV_MIN;
        else
            acc_next = acc_sum[VW-1:0];
    end

    // Target voltage: origin plus accumulator, saturated.
    always_comb
    begin
        tgt_sum = (VW + 1)'(origin_reg) + (VW + 1)'(acc_next);
        if (tgt_sum > (VW + 1)'(tas_pkg::CV_MAX))
            target = tas_pkg::CV_MAX;
        else if (tgt_sum < (VW + 1)'(tas_pkg::CV_MIN))
            target = tas_pkg::CV_MIN;
        else
            target = tgt_sum[VW-1:0];
        target_q = {target, {FW{1'b0}}};
    end

    // One-pole filter step with round-half-up on both the step and the output; code 0 bypasses it.
    always_comb
    begin
        diff     = (SW + 1)'(target_q) - (SW + 1)'(slew_reg);
        prod     = PW'(diff) * PW'($signed({1'b0, coef}));
        step     = (prod + PW'(32768)) >>> FW;
        slew_rnd = (SW + 1)'(slew_reg) + (SW + 1)'(step);
        cv_wide  = (SW - FW + 1)'((slew_rnd + (SW + 1)'(32768)) >>> FW);

        if (code_reg == '0)
        begin
            slew_next = target_q;
            cv_next   = target;
        end
        else
        begin
            slew_next = slew_rnd[SW-1:0];
            if (cv_wide > (SW - FW + 1)'(tas_pkg::CV_MAX))
                cv_next = tas_pkg::CV_MAX;
            else if (cv_wide < (SW - FW + 1)'(tas_pkg::CV_MIN))
                cv_next = tas_pkg::CV_MIN;
            else
                cv_next = cv_wide[VW-1:0];
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            origin_reg <= origin_level;
            delta_reg  <= delta_level;
            code_reg   <= slew_code;
            wgate_reg  <= write_gate;
            rgate_reg  <= reset_gate;
            wbtn_reg   <= write_button;
            rbtn_reg   <= reset_button;
        end
    end

    // State and output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            slew_reg      <= '0;
            trig_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (proc)
            begin
                acc_reg  <= acc_next;
                slew_reg <= slew_next;
                trig_reg <= trig_next;
            end
            if (proc)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            cv_reg     <= cv_next;
            wfired_reg <= wr_fire;
            rfired_reg <= rst_fire;
        end
    end

    // A reset trigger without a write leaves the accumulator at zero.
    a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc && rst_fire && !wr_fire |=> acc_reg == '0)
        else $error("accumulator not cleared by reset trigger");

    // Filter and accumulator state only move when a sample is processed.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !proc |=> $stable(acc_reg) && $stable(slew_reg) && $stable(trig_reg))
        else $error("state changed without a sample");

    // The button edge detector remembers the last button level.
    a_btn_track: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> trig_reg[tas_pkg::TRIG_WRITE_BTN] == $past(wbtn_reg))
        else $error("write button state lost");

    // The input side only stalls when both registers are full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled with room available");

endmodule

`default_nettype wire
